[hdl/des_pkg.sv]
// ----------------------------------------------------------------------------
// des_pkg
// shared types, codes, permutation tables and round function for the
// DES ECB/CBC cipher with PKCS#7 padding
// ----------------------------------------------------------------------------
package des_pkg;

    localparam int DES_QDEPTH = 2;

    localparam logic [2:0] CFG_KEY  = 3'd0;
    localparam logic [2:0] CFG_IV   = 3'd1;
    localparam logic [2:0] CFG_MODE = 3'd2;
    localparam logic [2:0] CFG_DIR  = 3'd3;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_LEN = 2'd1;
    localparam logic [1:0] ST_PAD = 2'd2;

    localparam logic [3:0] FULL_BYTES = 4'd8;
    localparam logic [3:0] LAST_ROUND = 4'd15;

    typedef enum logic [1:0] {
        OP_ENC,
        OP_DEC,
        OP_SHORT
    } t_op;

    typedef enum logic {
        BS_IDLE,
        BS_RUN
    } t_bstate;

    typedef struct packed {
        logic [63:0] data;
        t_op         op;
        logic        last;
    } t_job;

    localparam logic [6:0] IP_TAB [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    localparam logic [6:0] FP_TAB [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    localparam logic [5:0] E_TAB [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
    localparam logic [5:0] P_TAB [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
    localparam logic [6:0] PC1_TAB [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
    localparam logic [5:0] PC2_TAB [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
    // one bit per round: 1 means shift by two
    localparam logic ROT2_TAB [16] = '{0,0,1,1,1,1,1,1,0,1,1,1,1,1,1,0};

    localparam logic [3:0] SBOX [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    function automatic logic [63:0] f_ip(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(IP_TAB[i])];
        return r;
    endfunction

    function automatic logic [63:0] f_fp(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(FP_TAB[i])];
        return r;
    endfunction

    function automatic logic [55:0] f_pc1(input logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = v[64-int'(PC1_TAB[i])];
        return r;
    endfunction

    function automatic logic [47:0] f_pc2(input logic [55:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(PC2_TAB[i])];
        return r;
    endfunction

    function automatic logic [55:0] f_rotl(input logic [55:0] cd, input logic two);
        logic [27:0] c;
        logic [27:0] d;
        c = cd[55:28];
        d = cd[27:0];
        if (two) return {c[25:0], c[27:26], d[25:0], d[27:26]};
        return {c[26:0], c[27], d[26:0], d[27]};
    endfunction

    function automatic logic [55:0] f_rotr(input logic [55:0] cd, input logic two);
        logic [27:0] c;
        logic [27:0] d;
        c = cd[55:28];
        d = cd[27:0];
        if (two) return {c[1:0], c[27:2], d[1:0], d[27:2]};
        return {c[0], c[27:1], d[0], d[27:1]};
    endfunction

    function automatic logic [31:0] f_feistel(input logic [31:0] rv, input logic [47:0] k);
        logic [47:0] x;
        logic [31:0] s;
        logic [31:0] r;
        logic [5:0]  b;
        for (int i = 0; i < 48; i++) x[47-i] = rv[32-int'(E_TAB[i])];
        x = x ^ k;
        for (int i = 0; i < 8; i++) begin
            b = x[47-6*i -: 6];
            s[31-4*i -: 4] = SBOX[i][{b[5], b[0], b[4:1]}];
        end
        for (int i = 0; i < 32; i++) r[31-i] = s[32-int'(P_TAB[i])];
        return r;
    endfunction

endpackage

[hdl/des_front.sv]
// ----------------------------------------------------------------------------
// des_front
// accepts input beats, applies padding and length checks, queues DES jobs
// ----------------------------------------------------------------------------
module des_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_dir,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [63:0]       i_block_data,
    input  logic [3:0]        i_byte_count,
    input  logic              i_last_block,
    input  logic              i_full,
    output logic              o_push,
    output des_pkg::t_job     o_job
);
    import des_pkg::*;

    logic        r_pad;
    logic        n_pad;
    logic [3:0]  cnt;
    logic [63:0] padded;
    logic        take;

    assign cnt        = (i_byte_count > FULL_BYTES) ? FULL_BYTES : i_byte_count;
    assign o_in_ready = !i_full && !r_pad;
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            if (4'(j) < cnt) padded[63-8*j -: 8] = i_block_data[63-8*j -: 8];
            else padded[63-8*j -: 8] = {4'd0, FULL_BYTES - cnt};
        end
    end

    always_comb begin
        n_pad       = r_pad;
        o_push      = 1'b0;
        o_job.data  = i_block_data;
        o_job.op    = OP_ENC;
        o_job.last  = i_last_block;
        if (r_pad) begin
            // whole pad block after a full last block
            o_job.data = {8{8'h08}};
            o_job.last = 1'b1;
            if (!i_full) begin
                o_push = 1'b1;
                n_pad  = 1'b0;
            end
        end else if (take) begin
            o_push = 1'b1;
            if (i_dir) begin
                o_job.op = (cnt < FULL_BYTES) ? OP_SHORT : OP_DEC;
            end else if (i_last_block) begin
                if (cnt == FULL_BYTES) begin
                    o_job.last = 1'b0;
                    n_pad      = 1'b1;
                end else begin
                    o_job.data = padded;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad <= 1'b0;
        end else begin
            r_pad <= n_pad;
        end
    end

endmodule

[hdl/des_queue.sv]
// ----------------------------------------------------------------------------
// des_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module des_queue #(
    parameter int DEPTH = des_pkg::DES_QDEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  des_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output des_pkg::t_job o_job
);
    import des_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop) r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

endmodule

[hdl/des_back.sv]
// ----------------------------------------------------------------------------
// des_back
// iterative DES core, one round per cycle save output stalls, chaining, unpadding, output beat
// ----------------------------------------------------------------------------
module des_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [63:0]   i_key,
    input  logic [63:0]   i_iv,
    input  logic          i_iv_wr,
    input  logic          i_cbc,
    input  logic          i_dir,
    input  logic          i_q_valid,
    input  des_pkg::t_job i_q_job,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [63:0]   o_out_data,
    output logic [3:0]    o_out_bytes,
    output logic          o_out_last,
    output logic [1:0]    o_status
);
    import des_pkg::*;

    t_bstate     r_state, n_state;
    logic [3:0]  r_cnt, n_cnt;
    logic [31:0] r_l, n_l, r_r, n_r;
    logic [55:0] r_cd, n_cd;
    logic [63:0] r_data, n_data;
    t_op         r_op, n_op;
    logic        r_last, n_last;
    logic [63:0] r_chain, n_chain;
    logic        r_ov, n_ov;
    logic [63:0] r_od, n_od;
    logic [3:0]  r_ob, n_ob;
    logic        r_ol, n_ol;
    logic [1:0]  r_os, n_os;

    logic        out_free;
    logic [55:0] cd_enc;
    logic [47:0] subkey;
    logic [31:0] rnd_r;
    logic [63:0] blk;
    logic [63:0] pt;
    logic [63:0] ld_in;
    logic [63:0] ld_ip;
    logic [7:0]  pad;
    logic        pad_ok;
    logic [63:0] stripped;

    assign out_free = !r_ov || i_out_ready;
    assign cd_enc   = f_rotl(r_cd, ROT2_TAB[r_cnt]);
    assign subkey   = i_dir ? f_pc2(r_cd) : f_pc2(cd_enc);
    assign rnd_r    = r_l ^ f_feistel(r_r, subkey);
    assign blk      = f_fp({rnd_r, r_r});
    assign pt       = i_cbc ? (blk ^ r_chain) : blk;
    assign ld_in    = (i_q_job.op == OP_ENC && i_cbc) ? (i_q_job.data ^ r_chain)
                                                       : i_q_job.data;
    assign ld_ip    = f_ip(ld_in);
    assign pad      = pt[7:0];

    always_comb begin
        pad_ok   = (pad >= 8'd1) && (pad <= 8'd8);
        stripped = pt;
        for (int j = 0; j < 8; j++) begin
            if (8'(j) < pad) begin
                if (pt[8*j +: 8] != pad) pad_ok = 1'b0;
                stripped[8*j +: 8] = 8'd0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_l     = r_l;
        n_r     = r_r;
        n_cd    = r_cd;
        n_data  = r_data;
        n_op    = r_op;
        n_last  = r_last;
        n_chain = r_chain;
        n_ov    = r_ov && !i_out_ready;
        n_od    = r_od;
        n_ob    = r_ob;
        n_ol    = r_ol;
        n_os    = r_os;
        o_pop   = 1'b0;
        case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_job.op == OP_SHORT) begin
                        if (out_free) begin
                            o_pop = 1'b1;
                            n_ov  = 1'b1;
                            n_od  = '0;
                            n_ob  = '0;
                            n_ol  = i_q_job.last;
                            n_os  = ST_LEN;
                            if (i_q_job.last) n_chain = i_iv;
                        end
                    end else begin
                        o_pop   = 1'b1;
                        n_state = BS_RUN;
                        n_cnt   = '0;
                        n_l     = ld_ip[63:32];
                        n_r     = ld_ip[31:0];
                        n_cd    = f_pc1(i_key);
                        n_data  = i_q_job.data;
                        n_op    = i_q_job.op;
                        n_last  = i_q_job.last;
                    end
                end
            end
            BS_RUN: begin
                if (r_cnt != LAST_ROUND) begin
                    n_l   = r_r;
                    n_r   = rnd_r;
                    n_cd  = i_dir ? f_rotr(r_cd, ROT2_TAB[LAST_ROUND - r_cnt]) : cd_enc;
                    n_cnt = r_cnt + 1'b1;
                end else if (out_free) begin
                    n_state = BS_IDLE;
                    n_ov    = 1'b1;
                    n_ol    = r_last;
                    n_ob    = FULL_BYTES;
                    n_os    = ST_OK;
                    if (r_op == OP_ENC) begin
                        n_od    = blk;
                        n_chain = r_last ? i_iv : blk;
                    end else begin
                        n_od    = pt;
                        n_chain = r_last ? i_iv : r_data;
                        if (r_last) begin
                            if (pad_ok) begin
                                n_od = stripped;
                                n_ob = FULL_BYTES - pad[3:0];
                            end else begin
                                n_od = '0;
                                n_ob = '0;
                                n_os = ST_PAD;
                            end
                        end
                    end
                end
            end
            default: n_state = BS_IDLE;
        endcase
        if (i_iv_wr) n_chain = i_iv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_ov    <= 1'b0;
            r_chain <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_chain <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_l    <= n_l;
        r_r    <= n_r;
        r_cd   <= n_cd;
        r_data <= n_data;
        r_op   <= n_op;
        r_last <= n_last;
        r_od   <= n_od;
        r_ob   <= n_ob;
        r_ol   <= n_ol;
        r_os   <= n_os;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;
    assign o_out_bytes = r_ob;
    assign o_out_last  = r_ol;
    assign o_status    = r_os;

endmodule

[hdl/des_ecb_cbc_pkcs7_cipher.sv]
// ----------------------------------------------------------------------------
// des_ecb_cbc_pkcs7_cipher
// DES in ECB or CBC mode with PKCS#7 padding, one 8-byte block per beat
// ----------------------------------------------------------------------------
// a DES block goes from the input beat through the queue, the load into the
// round registers and sixteen rounds of the single round unit; a short block
// on decrypt goes straight to the output register once the output is free.
// one block at a time in the rounds; a full last encrypt block costs two blocks.
// reset: synchronous active low; key and iv 0, cbc mode, encrypt, queue empty.
module des_ecb_cbc_pkcs7_cipher #(
    parameter int QDEPTH = des_pkg::DES_QDEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_block_data,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last_block,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_out_data,
    output logic [3:0]  o_out_bytes,
    output logic        o_out_last,
    output logic [1:0]  o_status
);
    import des_pkg::*;

    logic [63:0] r_key;
    logic [63:0] r_iv;
    logic        r_cbc;
    logic        r_dir;
    logic        iv_wr;
    logic        q_full;
    logic        push;
    t_job        push_job;
    logic        pop;
    logic        q_valid;
    t_job        q_job;

    assign iv_wr = i_cfg_we && (i_cfg_idx == CFG_IV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_iv  <= '0;
            r_cbc <= 1'b1;
            r_dir <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY:  r_key <= i_cfg_data;
                CFG_IV:   r_iv  <= i_cfg_data;
                CFG_MODE: r_cbc <= i_cfg_data[0];
                CFG_DIR:  r_dir <= i_cfg_data[0];
                default:  ;
            endcase
        end
    end

    des_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dir        (r_dir),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_block_data (i_block_data),
        .i_byte_count (i_byte_count),
        .i_last_block (i_last_block),
        .i_full       (q_full),
        .o_push       (push),
        .o_job        (push_job)
    );

    des_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    des_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (r_key),
        .i_iv        (iv_wr ? i_cfg_data : r_iv),
        .i_iv_wr     (iv_wr),
        .i_cbc       (r_cbc),
        .i_dir       (r_dir),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_out_bytes (o_out_bytes),
        .o_out_last  (o_out_last),
        .o_status    (o_status)
    );

endmodule

[hdl/des_checker.sv]
// ----------------------------------------------------------------------------
// des_checker
// port-level checks on the output beats of the cipher
// ----------------------------------------------------------------------------
module des_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_out_data,
    input logic [3:0]  o_out_bytes,
    input logic        o_out_last,
    input logic [1:0]  o_status
);
    import des_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_out_bytes == 4'd0 && o_out_data == 64'd0)
        else $error("error beat carries data");

    a_pad_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_PAD |-> o_out_last)
        else $error("padding error not on last beat");

    a_short_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OK && o_out_bytes != FULL_BYTES |-> o_out_last)
        else $error("short ok beat not last");

endmodule

bind des_ecb_cbc_pkcs7_cipher des_checker u_chk (.*);

[verif/tb_des_ecb_cbc_pkcs7_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_des_ecb_cbc_pkcs7_cipher
// self-checking bench for the DES ECB/CBC cipher with PKCS#7 padding: a queue
// of beats, register writes and drain points feeds a bursty driver; each
// accepted beat runs through a DES predictor in the bench and the expected
// results are compared field by field against a monitor with random stalls
// ----------------------------------------------------------------------------
module tb_des_ecb_cbc_pkcs7_cipher;
    import des_pkg::*;

    typedef enum logic [1:0] {K_BEAT, K_CFG, K_DRAIN} t_kind;

    typedef struct {
        t_kind       kind;
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        last;
        logic [2:0]  idx;
    } t_pend;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  bytes;
        logic        last;
        logic [1:0]  status;
    } t_res;

    typedef logic [47:0] t_sched [16];

    localparam logic [63:0] PAD8 = 64'h0808080808080808;
    localparam logic [63:0] ONES = 64'h0101010101010101;
    localparam int SETTLE = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [63:0] i_block_data = '0;
    logic [3:0]  i_byte_count = '0;
    logic        i_last_block = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [63:0] o_out_data;
    logic [3:0]  o_out_bytes;
    logic        o_out_last;
    logic [1:0]  o_status;

    des_ecb_cbc_pkcs7_cipher dut (.*);

    always #4 i_clk = ~i_clk;

    t_pend  pending[$];
    t_res   expected_results[$];
    int     errors = 0;
    int     beats_queued = 0;

    // predictor state
    t_sched      p_sched;
    logic [63:0] p_iv = '0;
    logic [63:0] p_chain = '0;
    logic        p_cbc = 1'b1;
    logic        p_dec = 1'b0;

    function automatic t_sched key_schedule(input logic [63:0] key);
        t_sched      ks;
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        logic [47:0] k;
        for (int i = 0; i < 56; i++) cd[55-i] = key[64-int'(PC1_TAB[i])];
        c = cd[55:28];
        d = cd[27:0];
        for (int r = 0; r < 16; r++) begin
            c = ROT2_TAB[r] ? {c[25:0], c[27:26]} : {c[26:0], c[27]};
            d = ROT2_TAB[r] ? {d[25:0], d[27:26]} : {d[26:0], d[27]};
            cd = {c, d};
            for (int i = 0; i < 48; i++) k[47-i] = cd[56-int'(PC2_TAB[i])];
            ks[r] = k;
        end
        return ks;
    endfunction

    function automatic logic [31:0] round_fn(input logic [31:0] rv, input logic [47:0] k);
        logic [47:0] x;
        logic [31:0] s;
        logic [31:0] p;
        logic [5:0]  b;
        for (int i = 0; i < 48; i++) x[47-i] = rv[32-int'(E_TAB[i])];
        x = x ^ k;
        for (int i = 0; i < 8; i++) begin
            b = x[47-6*i -: 6];
            s[31-4*i -: 4] = SBOX[i][int'({b[5], b[0]}) * 16 + int'(b[4:1])];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(P_TAB[i])];
        return p;
    endfunction

    function automatic logic [63:0] des_crypt(input logic [63:0] blk, input t_sched ks,
                                              input logic decrypt);
        logic [63:0] v;
        logic [63:0] o;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] t;
        for (int i = 0; i < 64; i++) v[63-i] = blk[64-int'(IP_TAB[i])];
        l = v[63:32];
        r = v[31:0];
        for (int i = 0; i < 16; i++) begin
            t = r;
            r = l ^ round_fn(r, ks[decrypt ? 15 - i : i]);
            l = t;
        end
        v = {r, l};
        for (int i = 0; i < 64; i++) o[63-i] = v[64-int'(FP_TAB[i])];
        return o;
    endfunction

    function automatic logic [63:0] encrypt_chained(input logic [63:0] pt);
        logic [63:0] ct;
        ct = des_crypt(p_cbc ? pt ^ p_chain : pt, p_sched, 1'b0);
        p_chain = ct;
        return ct;
    endfunction

    function automatic void add_result(input logic [63:0] d, input logic [3:0] nb,
                                       input logic lst, input logic [1:0] st);
        t_res e;
        e.data = d;
        e.bytes = nb;
        e.last = lst;
        e.status = st;
        expected_results.push_back(e);
    endfunction

    function automatic void predict_block(input logic [63:0] data, input logic [3:0] cnt,
                                          input logic lst);
        int          n;
        int          p;
        logic [63:0] keep;
        logic [63:0] low;
        logic [63:0] pt;
        n = (cnt > FULL_BYTES) ? 8 : int'(cnt);
        if (!p_dec) begin
            if (!lst) begin
                add_result(encrypt_chained(data), FULL_BYTES, 1'b0, ST_OK);
            end else if (n == 8) begin
                add_result(encrypt_chained(data), FULL_BYTES, 1'b0, ST_OK);
                add_result(encrypt_chained(PAD8), FULL_BYTES, 1'b1, ST_OK);
                p_chain = p_iv;
            end else begin
                keep = (n == 0) ? 64'd0 : ~64'd0 << (64 - 8 * n);
                pt = (data & keep) | ((ONES * 64'(8 - n)) & ~keep);
                add_result(encrypt_chained(pt), FULL_BYTES, 1'b1, ST_OK);
                p_chain = p_iv;
            end
        end else if (n < 8) begin
            add_result('0, '0, lst, ST_LEN);
            if (lst) p_chain = p_iv;
        end else begin
            pt = des_crypt(data, p_sched, 1'b1);
            if (p_cbc) pt = pt ^ p_chain;
            p_chain = data;
            if (!lst) begin
                add_result(pt, FULL_BYTES, 1'b0, ST_OK);
            end else begin
                p_chain = p_iv;
                p = int'(pt[7:0]);
                low = (p == 8) ? ~64'd0 : ((64'd1 << (8 * (p % 8))) - 64'd1);
                if (p < 1 || p > 8 || (pt & low) != ((ONES * 64'(p)) & low))
                    add_result('0, '0, 1'b1, ST_PAD);
                else
                    add_result(pt & ~low, 4'(8 - p), 1'b1, ST_OK);
            end
        end
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [63:0] v);
        case (idx)
            CFG_KEY: begin
                p_sched = key_schedule(v);
            end
            CFG_IV: begin
                p_iv = v;
                p_chain = v;
            end
            CFG_MODE: begin
                p_cbc = v[0];
            end
            CFG_DIR: begin
                p_dec = v[0];
            end
            default: begin
            end
        endcase
    endfunction

    // ---------------- stimulus generation ----------------
    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic void queue_beat(input logic [63:0] d, input logic [3:0] c, input logic l);
        t_pend b;
        b.kind = K_BEAT;
        b.data = d;
        b.cnt = c;
        b.last = l;
        b.idx = '0;
        pending.push_back(b);
        beats_queued++;
    endfunction

    function automatic void queue_reg(input logic [2:0] idx, input logic [63:0] v);
        t_pend b;
        b.kind = K_CFG;
        b.data = v;
        b.cnt = '0;
        b.last = 1'b0;
        b.idx = idx;
        pending.push_back(b);
    endfunction

    function automatic void queue_drain();
        t_pend b;
        b.kind = K_DRAIN;
        b.data = '0;
        b.cnt = '0;
        b.last = 1'b0;
        b.idx = '0;
        pending.push_back(b);
    endfunction

    // plaintext message, mostly full blocks and a random final count
    function automatic void queue_plain_msg();
        int nblk;
        nblk = $urandom_range(0, 5);
        for (int i = 0; i < nblk; i++) begin
            // occasionally a short count on an inner block, which is ignored
            queue_beat(rnd64(), ($urandom_range(0, 9) == 0) ? 4'($urandom) : FULL_BYTES, 1'b0);
        end
        queue_beat(rnd64(), ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8)),
                   1'b1);
    endfunction

    // properly padded ciphertext message under the given settings, sometimes broken
    function automatic void queue_cipher_msg(input logic [63:0] key, input logic [63:0] iv,
                                             input logic cbc);
        t_sched      ks;
        logic [63:0] cv;
        logic [63:0] blk;
        logic [63:0] keep;
        int          total;
        int          nblk;
        int          r;
        int          brk;
        ks = key_schedule(key);
        cv = iv;
        total = $urandom_range(0, 40);
        nblk = total / 8 + 1;
        brk = $urandom_range(0, 7);
        for (int i = 0; i < nblk; i++) begin
            blk = rnd64();
            if (i == nblk - 1) begin
                r = total % 8;
                keep = (r == 0) ? 64'd0 : ~64'd0 << (64 - 8 * r);
                blk = (blk & keep) | ((ONES * 64'(8 - r)) & ~keep);
            end
            blk = des_crypt(cbc ? blk ^ cv : blk, ks, 1'b0);
            cv = blk;
            if (i == nblk - 1 && brk == 0) blk[$urandom_range(0, 63)] ^= 1'b1;
            if (brk == 1 && i == $urandom_range(0, nblk - 1))
                queue_beat(blk, 4'($urandom_range(0, 7)), i == nblk - 1);
            else
                queue_beat(blk, (brk == 2) ? 4'($urandom_range(9, 15)) : FULL_BYTES,
                           i == nblk - 1);
        end
    endfunction

    function automatic void queue_phase(input logic [63:0] key, input logic [63:0] iv,
                                        input logic cbc, input logic dec, input int nbeats);
        int stop;
        queue_reg(CFG_KEY, key);
        queue_reg(CFG_IV, iv);
        queue_reg(CFG_MODE, (rnd64() << 1) | 64'(cbc));
        queue_reg(CFG_DIR, (rnd64() << 1) | 64'(dec));
        queue_reg(3'($urandom_range(4, 7)), rnd64());
        stop = beats_queued + nbeats;
        while (beats_queued < stop) begin
            case ($urandom_range(0, 9))
                0: queue_beat(rnd64(), 4'($urandom), 1'($urandom_range(0, 1)));
                1: if (beats_queued > stop - nbeats / 2 && $urandom_range(0, 5) == 0)
                       queue_drain();
                default: begin
                    if (dec) queue_cipher_msg(key, iv, cbc);
                    else queue_plain_msg();
                end
            endcase
        end
        queue_drain();
    endfunction

    initial begin
        logic [63:0] k;
        logic [63:0] v;
        p_sched = key_schedule('0);
        // encrypt under reset settings: field extremes
        queue_beat('0, '0, 1'b1);
        queue_beat('1, FULL_BYTES, 1'b1);
        queue_beat('1, 4'd3, 1'b0);
        queue_beat(rnd64(), 4'd15, 1'b1);
        queue_beat(rnd64(), 4'd7, 1'b1);
        queue_beat(rnd64(), 4'd1, 1'b1);
        queue_beat('1, FULL_BYTES, 1'b0);
        queue_beat('0, 4'd15, 1'b0);
        queue_beat(rnd64(), FULL_BYTES, 1'b1);
        queue_drain();
        // decrypt, ecb, zero key: short, bad padding, good padding
        k = 64'h0;
        v = 64'h0;
        queue_reg(CFG_MODE, '0);
        queue_reg(CFG_DIR, 64'd1);
        queue_beat(rnd64(), 4'd0, 1'b0);
        queue_beat(rnd64(), 4'd7, 1'b1);
        queue_beat(des_crypt('0, key_schedule(k), 1'b0), FULL_BYTES, 1'b1);
        queue_beat(des_crypt('1, key_schedule(k), 1'b0), FULL_BYTES, 1'b1);
        queue_beat(des_crypt(PAD8, key_schedule(k), 1'b0), FULL_BYTES, 1'b1);
        queue_beat(des_crypt(64'h4142430505050505, key_schedule(k), 1'b0), 4'd12, 1'b1);
        queue_beat(des_crypt(64'h4142434445464701, key_schedule(k), 1'b0), FULL_BYTES, 1'b1);
        queue_beat(des_crypt(64'h4142434445460302, key_schedule(k), 1'b0), FULL_BYTES, 1'b1);
        queue_drain();
        queue_phase('0, '0, 1'b1, 1'b0, 100);
        queue_phase('1, '1, 1'b0, 1'b0, 100);
        queue_phase('0, '1, 1'b1, 1'b1, 100);
        queue_phase('1, '0, 1'b0, 1'b1, 100);
        while (beats_queued < 1250)
            queue_phase(rnd64(), rnd64(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        $urandom_range(60, 160));
    end

    // ---------------- driver ----------------
    int burst_left = 0;
    int gap_left = 0;
    int quiet = 0;

    always @(posedge i_clk) begin
        logic  took;
        logic  cfg_n;
        logic  vld_n;
        t_pend nx;
        cfg_n = 1'b0;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            quiet <= 0;
        end else begin
            took = i_in_valid && o_in_ready;
            vld_n = i_in_valid && !took;
            if (took) predict_block(i_block_data, i_byte_count, i_last_block);
            quiet <= (expected_results.size() == 0 && !i_in_valid) ? quiet + 1 : 0;
            if (!i_in_valid || took) begin
                if (pending.size() != 0) begin
                    nx = pending[0];
                    case (nx.kind)
                        K_CFG: begin
                            if (!took && quiet >= SETTLE) begin
                                cfg_n = 1'b1;
                                i_cfg_idx <= nx.idx;
                                i_cfg_data <= nx.data;
                                apply_reg(nx.idx, nx.data);
                                void'(pending.pop_front());
                            end
                        end
                        K_DRAIN: begin
                            if (!took && quiet >= 2) void'(pending.pop_front());
                        end
                        default: begin
                            if (gap_left > 0) begin
                                gap_left <= gap_left - 1;
                            end else begin
                                vld_n = 1'b1;
                                i_block_data <= nx.data;
                                i_byte_count <= nx.cnt;
                                i_last_block <= nx.last;
                                void'(pending.pop_front());
                                if (burst_left <= 1) begin
                                    burst_left <= $urandom_range(1, 40);
                                    gap_left <= ($urandom_range(0, 2) == 0) ? 0
                                                : $urandom_range(1, 30);
                                end else begin
                                    burst_left <= burst_left - 1;
                                end
                            end
                        end
                    endcase
                end
            end
            i_in_valid <= vld_n;
        end
        i_cfg_we <= cfg_n;
    end

    // ---------------- receiver ----------------
    int cycle_no = 0;
    int hold_left = 0;
    int ready_mode = 0;

    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no % 500 == 0) ready_mode <= $urandom_range(0, 3);
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (cycle_no == 3000 || $urandom_range(0, 4000) == 0) begin
            hold_left <= $urandom_range(200, 400);
            i_out_ready <= 1'b0;
        end else begin
            case (ready_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= $urandom_range(0, 1);
                2: i_out_ready <= ($urandom_range(0, 7) == 0);
                default: i_out_ready <= (cycle_no % 5 != 0);
            endcase
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report("unexpected beat", o_out_data, '0);
            end else begin
                e = expected_results.pop_front();
                if (o_out_data !== e.data) report("data", o_out_data, e.data);
                if (o_out_bytes !== e.bytes) report("bytes", 64'(o_out_bytes), 64'(e.bytes));
                if (o_out_last !== e.last) report("last", 64'(o_out_last), 64'(e.last));
                if (o_status !== e.status) report("status", 64'(o_status), 64'(e.status));
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (pending.size() != 0 || i_in_valid || expected_results.size() != 0);
        repeat (60) @(posedge i_clk);
        if (expected_results.size() != 0) errors++;
        if (errors == 0) begin
            $display("tb_des_ecb_cbc_pkcs7_cipher OK");
        end else begin
            $display("tb_des_ecb_cbc_pkcs7_cipher NOT OK");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_des_ecb_cbc_pkcs7_cipher NOT OK");
        $finish;
    end

endmodule
